### sv/clip_and_fade_rgb565_block_assert.svh
// Assertion macros used by the checker file of the clip and fade block.
`ifndef CLIP_AND_FADE_RGB565_BLOCK_ASSERT_SVH
`define CLIP_AND_FADE_RGB565_BLOCK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CAF_ASSERT_SAME_CYCLE(name, clock, dis, ante, cons) \
  name: assert property (@(posedge clock) disable iff (dis) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CAF_ASSERT_NEXT_CYCLE(name, clock, dis, ante, cons) \
  name: assert property (@(posedge clock) disable iff (dis) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### sv/caf_pkg.sv
// Constants, types and helper functions of the clip and fade block.
package caf_pkg;

  localparam int unsigned BUFFER_PIXELS = 256;
  localparam logic [10:0] SIZE_MAX      = 11'd1024;

  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FADE_ALPHA    = 2'd2;

  typedef struct packed {
    logic        keep;
    logic        area_check;
    logic [10:0] copy_w;
    logic [10:0] copy_h;
    logic [9:0]  x;
    logic [9:0]  y;
    logic        last;
    logic [15:0] pixel;
  } geom_t;

  // Block sizes: zero acts as one, anything above the maximum as the maximum.
  function automatic logic [10:0] clamp_block(logic [10:0] v);
    logic [10:0] r;
    r = v;
    if (v == 11'd0) begin
      r = 11'd1;
    end else if (v > SIZE_MAX) begin
      r = SIZE_MAX;
    end
    return r;
  endfunction

  // Screen sizes: zero stays zero, anything above the maximum is the maximum.
  function automatic logic [10:0] clamp_screen(logic [10:0] v);
    logic [10:0] r;
    r = v;
    if (v > SIZE_MAX) begin
      r = SIZE_MAX;
    end
    return r;
  endfunction

  // Truncating division by 255, exact for every product of a 6-bit channel
  // and an 8-bit factor.
  function automatic logic [5:0] div255(logic [13:0] x);
    logic [14:0] s;
    s = {1'b0, x} + 15'(x[13:8]) + 15'd1;
    return s[13:8];
  endfunction

endpackage

### sv/clip_and_fade_rgb565_block.sv
// Clip and fade stage for RGB565 image blocks, with its three pipeline registers.
//
// The block takes the pixels of one decoded image block in raster order, one
// item per pixel, each carrying the block's signed screen position and size.
// Internal column and row counters place each pixel inside its block; they
// advance on every accepted item, wrap at the end of a row and at the end of
// the block, and are never reset by a change of geometry. Pixels that fall
// outside the window [0, screen_width) x [0, screen_height) give no result.
// Each kept pixel has its red, green and blue channels scaled by fade_alpha
// and divided by 255 with truncation, and leaves with its screen coordinates;
// last_kept marks the bottom-right pixel of the visible part of the block.
// When a block is partly clipped or faded and its visible area exceeds
// BUFFER_PIXELS (256), every pixel of that block is dropped; a block fully on
// screen at full brightness always passes unchanged. The block accepts one
// item in every cycle when the output side is not stalled. An accepted item
// passes from the input register to the clipping stage register (window
// bounds and screen coordinates), and the area multiplier and the three
// channel multipliers then feed the output register. Stall runs back through
// the stages, so a held output only stops the input once all three registers
// are full. Configuration writes are taken at any time and are expected only
// while the block is idle.
module clip_and_fade_rgb565_block (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [10:0] block_x,
  input  logic signed [10:0] block_y,
  input  logic [10:0]        block_w,
  input  logic [10:0]        block_h,
  input  logic [15:0]        pixel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         out_x,
  output logic [9:0]         out_y,
  output logic [15:0]        color,
  output logic               last_kept
);
  import caf_pkg::*;

  // Configuration registers.
  logic [10:0] screen_width;
  logic [10:0] screen_height;
  logic [7:0]  fade_alpha;

  // Position of the next pixel inside its block.
  logic [9:0] column_count;
  logic [9:0] row_count;

  // Input register.
  logic               s1_valid;
  logic signed [10:0] s1_bx;
  logic signed [10:0] s1_by;
  logic [10:0]        s1_bw;
  logic [10:0]        s1_bh;
  logic [15:0]        s1_pixel;
  logic [9:0]         s1_col;
  logic [9:0]         s1_row;

  // Clipping stage register.
  logic  s2_valid;
  geom_t s2;
  geom_t s2_next;

  // Handshake through the stages: a stage may load when it is empty or when
  // the stage after it is taking its contents.
  logic ready_out;
  logic ready_s2;
  logic in_accept;

  assign ready_out = !out_valid || !out_stall;
  assign ready_s2  = !s2_valid || ready_out;
  assign in_stall  = s1_valid && !ready_s2;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 11'd320;
      screen_height <= 11'd240;
      fade_alpha    <= 8'd255;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_wdata;
        REG_SCREEN_HEIGHT: screen_height <= cfg_wdata;
        REG_FADE_ALPHA:    fade_alpha    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // The counters follow the size that arrives with each pixel. A column count
  // of 1023 always wraps, since no block is wider than 1024.
  logic [10:0] in_bw;
  logic [10:0] in_bh;
  logic [9:0]  column_count_next;
  logic [9:0]  row_count_next;

  assign in_bw = clamp_block(block_w);
  assign in_bh = clamp_block(block_h);

  always_comb begin
    column_count_next = column_count + 10'd1;
    row_count_next    = row_count;
    if ({1'b0, column_count} + 11'd1 >= in_bw) begin
      column_count_next = 10'd0;
      if ({1'b0, row_count} + 11'd1 >= in_bh) begin
        row_count_next = 10'd0;
      end else begin
        row_count_next = row_count + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 10'd0;
      row_count    <= 10'd0;
      s1_valid     <= 1'b0;
    end else begin
      if (in_accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_bx    <= block_x;
      s1_by    <= block_y;
      s1_bw    <= in_bw;
      s1_bh    <= in_bh;
      s1_pixel <= pixel;
      s1_col   <= column_count;
      s1_row   <= row_count;
    end
  end

  // Clipping stage. All coordinates are 13-bit signed, which holds every sum
  // of a position, a size and a counter.
  logic signed [12:0] bx_e, by_e, right_e, bottom_e, sw_e, sh_e;
  logic signed [12:0] cl, ct, cr, cb, sx, sy, cw, ch;
  logic               on_screen;

  always_comb begin
    bx_e      = {{2{s1_bx[10]}}, s1_bx};
    by_e      = {{2{s1_by[10]}}, s1_by};
    right_e   = bx_e + $signed({2'b00, s1_bw});
    bottom_e  = by_e + $signed({2'b00, s1_bh});
    sw_e      = $signed({2'b00, clamp_screen(screen_width)});
    sh_e      = $signed({2'b00, clamp_screen(screen_height)});
    cl        = bx_e[12] ? 13'sd0 : bx_e;
    ct        = by_e[12] ? 13'sd0 : by_e;
    cr        = (right_e > sw_e) ? sw_e : right_e;
    cb        = (bottom_e > sh_e) ? sh_e : bottom_e;
    sx        = bx_e + $signed({3'b000, s1_col});
    sy        = by_e + $signed({3'b000, s1_row});
    cw        = cr - cl;
    ch        = cb - ct;
    on_screen = !bx_e[12] && !by_e[12] && (right_e <= sw_e) && (bottom_e <= sh_e);

    s2_next.keep       = (cr > cl) && (cb > ct) && (sx >= cl) && (sx < cr) &&
                         (sy >= ct) && (sy < cb);
    s2_next.area_check = !(on_screen && (fade_alpha == 8'd255));
    s2_next.copy_w     = cw[10:0];
    s2_next.copy_h     = ch[10:0];
    s2_next.x          = sx[9:0];
    s2_next.y          = sy[9:0];
    s2_next.last       = (sx == cr - 13'sd1) && (sy == cb - 13'sd1);
    s2_next.pixel      = s1_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready_s2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_s2 && s1_valid) begin
      s2 <= s2_next;
    end
  end

  // Area test and fade. A clipped or faded block whose visible area is too
  // large for the buffer is dropped in full.
  logic [21:0] area;
  logic        keep_final;
  logic [13:0] r_prod;
  logic [13:0] g_prod;
  logic [13:0] b_prod;
  logic [5:0]  r_q;
  logic [5:0]  g_q;
  logic [5:0]  b_q;

  always_comb begin
    area       = 22'(s2.copy_w) * 22'(s2.copy_h);
    keep_final = s2.keep && !(s2.area_check && (area > 22'(BUFFER_PIXELS)));
    r_prod     = 14'(s2.pixel[15:11]) * 14'(fade_alpha);
    g_prod     = 14'(s2.pixel[10:5]) * 14'(fade_alpha);
    b_prod     = 14'(s2.pixel[4:0]) * 14'(fade_alpha);
    r_q        = div255(r_prod);
    g_q        = div255(g_prod);
    b_q        = div255(b_prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_out) begin
      out_valid <= s2_valid && keep_final;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && s2_valid) begin
      out_x     <= s2.x;
      out_y     <= s2.y;
      color     <= {r_q[4:0], g_q, b_q[4:0]};
      last_kept <= s2.last;
    end
  end

endmodule

### sv/caf_checker.sv
// Port-level assertions of the clip and fade block, bound to its top level.
`include "clip_and_fade_rgb565_block_assert.svh"

module caf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [9:0]  out_x,
  input logic [9:0]  out_y,
  input logic [15:0] color,
  input logic        last_kept
);

  // A result held by the receiver stays, unchanged.
  `CAF_ASSERT_NEXT_CYCLE(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_x) && $stable(out_y) && $stable(color) && $stable(last_kept))

  // Reset leaves the pipeline empty: no result and room for a new item.
  `CAF_ASSERT_NEXT_CYCLE(a_reset_empty, clk, 1'b0, rst, !out_valid && !in_stall)

  // With the output side flowing, the input is never held back.
  `CAF_ASSERT_SAME_CYCLE(a_flow_through, clk, rst, !out_stall, !in_stall)

endmodule

bind clip_and_fade_rgb565_block caf_checker u_caf_checker (.*);

### tb/clip_and_fade_rgb565_block_test.sv
// Self-checking testbench for the RGB565 clip and fade block.
module clip_and_fade_rgb565_block_test;
  timeunit 1ns;
  timeprecision 1ps;
  import caf_pkg::*;

  // Cycles with nothing accepted on either side before the run is abandoned.
  // A correct run never comes near this: stall and gap bursts always end and
  // the pipeline is only three stages deep.
  localparam int QUIET_LIMIT   = 4000;
  // Cycles allowed for items that give no result to leave the pipeline.
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASES        = 12;
  // Blocks run past this target, by about seventy items a phase on average.
  localparam int PHASE_ITEMS   = 60;

  // One pixel item as it is offered to the block.
  typedef struct {
    logic signed [10:0] x;
    logic signed [10:0] y;
    logic [10:0]        w;
    logic [10:0]        h;
    logic [15:0]        rgb;
  } block_pixel_t;

  // One pixel as it should leave the block.
  typedef struct {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [15:0] rgb;
    logic        last;
  } screen_pixel_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wen = 1'b0;
  logic [1:0]         cfg_index = REG_SCREEN_WIDTH;
  logic [10:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [10:0] block_x = '0;
  logic signed [10:0] block_y = '0;
  logic [10:0]        block_w = 11'd1;
  logic [10:0]        block_h = 11'd1;
  logic [15:0]        pixel = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [9:0]         out_x;
  logic [9:0]         out_y;
  logic [15:0]        color;
  logic               last_kept;

  // Our own copy of the registers and of the position counters.
  logic [10:0] screen_w_now = 11'd320;
  logic [10:0] screen_h_now = 11'd240;
  logic [7:0]  alpha_now    = 8'd255;
  int          col_pos = 0;
  int          row_pos = 0;

  block_pixel_t  pixels_to_send[$];
  screen_pixel_t pixels_due[$];
  block_pixel_t  pixel_on_bus;

  int pushed_count = 0;
  int failures     = 0;
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int quiet        = 0;
  // calm switches all idling off for the last part of the run; drain holds
  // the output side open while the pipeline empties.
  bit calm  = 1'b0;
  bit drain = 1'b0;

  clip_and_fade_rgb565_block u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .block_x   (block_x),
    .block_y   (block_y),
    .block_w   (block_w),
    .block_h   (block_h),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .color     (color),
    .last_kept (last_kept)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // A screen dimension as the block sees it: anything above 1024 is 1024.
  function automatic int visible_span(input logic [10:0] d);
    return (d > 11'd1024) ? 1024 : int'(d);
  endfunction

  // Works out what one accepted pixel should give, and moves the column and
  // row counters on exactly as the block does, result or not.
  function automatic bit fade_and_clip(input block_pixel_t p, output screen_pixel_t r);
    int bx, by, bw, bh, sw, sh;
    int cl, ct, cr, cb, sx, sy;
    int red, grn, blu;
    bit keep, whole;
    bx = p.x;
    by = p.y;
    bw = p.w;
    bh = p.h;
    // Block sizes of zero act as one, sizes above 1024 as 1024.
    if (bw == 0) bw = 1;
    else if (bw > 1024) bw = 1024;
    if (bh == 0) bh = 1;
    else if (bh > 1024) bh = 1024;
    sw = visible_span(screen_w_now);
    sh = visible_span(screen_h_now);

    // The visible rectangle of the block, in screen coordinates.
    cl = (bx < 0) ? 0 : bx;
    ct = (by < 0) ? 0 : by;
    cr = (bx + bw > sw) ? sw : bx + bw;
    cb = (by + bh > sh) ? sh : by + bh;
    sx = bx + col_pos;
    sy = by + row_pos;

    keep  = cr > cl && cb > ct && sx >= cl && sx < cr && sy >= ct && sy < cb;
    whole = bx >= 0 && by >= 0 && bx + bw <= sw && by + bh <= sh;
    // A clipped or faded block whose visible part will not fit the buffer
    // is dropped as a whole; an untouched block always gets through.
    if (keep && !(whole && alpha_now == 8'd255) &&
        (cr - cl) * (cb - ct) > int'(BUFFER_PIXELS)) begin
      keep = 1'b0;
    end

    red    = int'(p.rgb[15:11]) * int'(alpha_now) / 255;
    grn    = int'(p.rgb[10:5]) * int'(alpha_now) / 255;
    blu    = int'(p.rgb[4:0]) * int'(alpha_now) / 255;
    r.x    = sx[9:0];
    r.y    = sy[9:0];
    r.rgb  = {red[4:0], grn[5:0], blu[4:0]};
    r.last = (sx == cr - 1) && (sy == cb - 1);

    // Raster order: wrap the column at the end of a row, the row at the end
    // of the block. The counters never see the geometry change otherwise.
    if (col_pos + 1 >= bw || col_pos >= 1023) begin
      col_pos = 0;
      if (row_pos + 1 >= bh || row_pos >= 1023) row_pos = 0;
      else row_pos++;
    end else begin
      col_pos++;
    end
    return keep;
  endfunction

  // Input driver. A new item is only put on the bus once the previous one
  // has been taken, so valid never falls while the block stalls it.
  always @(posedge clk) begin
    screen_pixel_t shown;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (fade_and_clip(pixel_on_bus, shown)) pixels_due.push_back(shown);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && pixels_to_send.size() > 0 &&
                     $urandom_range(0, 99) < in_idle_pct) begin
          // This cycle is the first of a gap with no item on the bus.
          gap_left = $urandom_range(0, 18);
          in_valid <= 1'b0;
        end else if (pixels_to_send.size() > 0) begin
          pixel_on_bus = pixels_to_send.pop_front();
          block_x  <= pixel_on_bus.x;
          block_y  <= pixel_on_bus.y;
          block_w  <= pixel_on_bus.w;
          block_h  <= pixel_on_bus.h;
          pixel    <= pixel_on_bus.rgb;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall, in bursts of random length.
  always @(posedge clk) begin
    if (rst || drain || calm) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < out_idle_pct) begin
      stall_left = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  // Output monitor: every pixel taken is checked against the oldest one due.
  always @(posedge clk) begin
    screen_pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pixels_due.size() == 0) begin
        $error("pixel at (%0d,%0d) came out with none due", out_x, out_y);
        failures++;
      end else begin
        want = pixels_due.pop_front();
        compare_field("out_x", 16'(want.x), 16'(out_x));
        compare_field("out_y", 16'(want.y), 16'(out_y));
        compare_field("color", want.rgb, color);
        compare_field("last_kept", 16'(want.last), 16'(last_kept));
      end
    end
  end

  // Watchdog: a hung block or a lost result shows up as a long quiet spell.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [15:0] any_rgb();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(0, 65535));
  endfunction

  // A position that mostly straddles or hugs the screen edges, and now and
  // then lands anywhere in the signed range.
  function automatic logic signed [10:0] near_edge(input logic [10:0] dim, input int size);
    int v;
    if ($urandom_range(0, 9) == 0) begin
      v = $urandom_range(0, 2047);
      return v[10:0];
    end
    v = $urandom_range(0, visible_span(dim) + 2 * size + 4) - size - 2;
    if (v < -1024) v = -1024;
    if (v > 1023) v = 1023;
    return v[10:0];
  endfunction

  task automatic push_pixel(input logic signed [10:0] x, input logic signed [10:0] y,
                            input logic [10:0] w, input logic [10:0] h,
                            input logic [15:0] rgb);
    block_pixel_t p;
    p.x   = x;
    p.y   = y;
    p.w   = w;
    p.h   = h;
    p.rgb = rgb;
    pixels_to_send.push_back(p);
    pushed_count++;
  endtask

  task automatic add_block(input logic signed [10:0] x, input logic signed [10:0] y,
                           input logic [10:0] w, input logic [10:0] h, input int count);
    for (int i = 0; i < count; i++) push_pixel(x, y, w, h, any_rgb());
  endtask

  // A 1x1 item always brings both counters back to zero, so it realigns the
  // raster after a cut-short or mangled block.
  task automatic add_resync();
    push_pixel(near_edge(screen_w_now, 1), near_edge(screen_h_now, 1),
               11'($urandom_range(0, 1)), 11'($urandom_range(0, 1)), any_rgb());
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [10:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SCREEN_WIDTH:  screen_w_now = val;
      REG_SCREEN_HEIGHT: screen_h_now = val;
      REG_FADE_ALPHA:    alpha_now = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Waits until every item has gone in and every due pixel has come out,
  // then gives items without a result time to leave the pipeline.
  task automatic settle();
    while (pixels_to_send.size() != 0 || in_valid || pixels_due.size() != 0) begin
      @(posedge clk);
    end
    drain = 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);
    drain = 1'b0;
  endtask

  initial begin
    int kind, bw, bh, n, target;
    int sw_set, sh_set, alpha_set;
    logic signed [10:0] bx, by;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed items at the reset settings: 320x240 screen, full brightness.
    in_idle_pct  = 10;
    out_idle_pct = 10;
    push_pixel(0, 0, 1, 1, 16'hFFFF);           // top-left corner, unchanged
    push_pixel(319, 239, 1, 1, 16'h0000);       // bottom-right corner
    push_pixel(320, 0, 1, 1, 16'h1234);         // just off the right edge
    push_pixel(-1024, -1024, 0, 0, 16'hFFFF);   // zero sizes act as one, off screen
    add_block(-1, -1, 2, 2, 4);                 // only its last pixel is visible
    add_block(318, 238, 3, 2, 6);               // clipped on the right
    push_pixel(1023, 1023, 2047, 2047, 16'hA5A5); // oversized, off screen
    push_pixel(5, 5, 1, 1, 16'hF800);
    // Clipped area far above the buffer size: the whole block goes.
    add_block(0, 0, 1024, 1024, 3);
    push_pixel(0, 0, 0, 0, 16'h07E0);
    // Geometry changes in the middle of a block; the counters carry on.
    add_block(0, 0, 3, 1, 2);
    push_pixel(100, 100, 2, 1, 16'h001F);
    settle();

    for (int p = 1; p <= PHASES; p++) begin
      // Register settings: the extremes first, then random ones.
      alpha_set = $urandom_range(0, 255);
      case (p)
        1: begin sw_set = 1024; sh_set = 1024; alpha_set = 255; end
        2: begin sw_set = 1;    sh_set = 1;    alpha_set = 0;   end
        3: begin sw_set = 0;    sh_set = 240;                   end
        4: begin sw_set = 2047; sh_set = 2047; alpha_set = 254; end
        5: begin sw_set = 40;   sh_set = 30;   alpha_set = 128; end
        6: begin sw_set = 1024; sh_set = 1;    alpha_set = 255; end
        7: begin sw_set = 1;    sh_set = 1024;                  end
        8: begin sw_set = 37;   sh_set = 0;                     end
        default: begin
          sw_set = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 64);
          sh_set = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 64);
          if ($urandom_range(0, 3) == 0) alpha_set = 255;
        end
      endcase
      set_reg(REG_SCREEN_WIDTH, 11'(sw_set));
      set_reg(REG_SCREEN_HEIGHT, 11'(sh_set));
      set_reg(REG_FADE_ALPHA, 11'(alpha_set));

      in_idle_pct  = (p % 3 == 0) ? 0 : $urandom_range(3, 25);
      out_idle_pct = (p % 4 == 2) ? 0 : $urandom_range(3, 25);
      if (p == PHASES) calm = 1'b1;

      target = pushed_count + PHASE_ITEMS;
      while (pushed_count < target) begin
        kind = $urandom_range(0, 99);
        if (kind < 62) begin
          // Complete small block, the bulk of the traffic.
          bw = $urandom_range(1, 12);
          bh = $urandom_range(1, 12);
          bx = near_edge(screen_w_now, bw);
          by = near_edge(screen_h_now, bh);
          add_block(bx, by, 11'(bw), 11'(bh), bw * bh);
        end else if (kind < 67) begin
          // Complete block whose area straddles the buffer size.
          bw = $urandom_range(15, 22);
          bh = $urandom_range(13, 20);
          bx = near_edge(screen_w_now, bw);
          by = near_edge(screen_h_now, bh);
          add_block(bx, by, 11'(bw), 11'(bh), bw * bh);
        end else if (kind < 79) begin
          // The first few pixels of a large block, raw sizes up to the
          // field's limit, then a realignment.
          bw = $urandom_range(13, 2047);
          bh = $urandom_range(1, 2047);
          bx = near_edge(screen_w_now, (bw > 1024) ? 1024 : bw);
          by = near_edge(screen_h_now, (bh > 1024) ? 1024 : bh);
          add_block(bx, by, 11'(bw), 11'(bh), $urandom_range(1, 40));
          add_resync();
        end else if (kind < 90) begin
          // A block cut short, sometimes followed by pixels that bring a
          // different geometry before the raster has wrapped.
          bw = $urandom_range(2, 10);
          bh = $urandom_range(2, 10);
          bx = near_edge(screen_w_now, bw);
          by = near_edge(screen_h_now, bh);
          add_block(bx, by, 11'(bw), 11'(bh), $urandom_range(1, bw * bh - 1));
          if ($urandom_range(0, 1) == 1) begin
            bw = $urandom_range(1, 12);
            bh = $urandom_range(1, 12);
            if ($urandom_range(0, 1) == 1) bx = near_edge(screen_w_now, bw);
            add_block(bx, by, 11'(bw), 11'(bh), $urandom_range(1, 12));
          end
          add_resync();
        end else begin
          // Noise over the whole of every field.
          n = $urandom_range(1, 5);
          repeat (n) begin
            push_pixel(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                       11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                       16'($urandom_range(0, 65535)));
          end
          add_resync();
        end
      end
      settle();
    end

    if (failures == 0 && pixels_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
